// ----- rtl/fp8sr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp8sr_pkg: shared constants for the FP32 to FP8 converter
// Field widths of the single-precision input and the 8-bit result, and the
// reset value of the exponent width register.
// ----------------------------------------------------------------------------
package fp8sr_pkg;

  localparam int unsigned FracW    = 23;
  localparam int unsigned Fp32ExpW = 8;
  localparam int unsigned Fp32W    = 32;
  localparam int unsigned RndW     = 23;
  localparam int unsigned Fp8W     = 8;
  localparam int unsigned CfgW     = 3;

  localparam logic [Fp32ExpW-1:0] Fp32ExpAllOnes = 8'hFF;
  localparam logic signed [9:0]   Fp32Bias       = 10'sd127;

  localparam logic [CfgW-1:0] ExpBitsMin   = 3'd2;
  localparam logic [CfgW-1:0] ExpBitsMax   = 3'd6;
  localparam logic [CfgW-1:0] ExpBitsReset = 3'd4;

  // mantissa width plus discarded width is always 23
  localparam logic [CfgW-1:0] MantPlusExp = 3'd7;
  localparam logic [4:0]      DropBase    = 5'd16;

  localparam logic [Fp8W-2:0] MagAllOnes = 7'h7F;

endpackage

// ----- rtl/fp8sr_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp8sr_convert: single-pass FP32 to FP8 conversion
// Rebias, subnormal shift, stochastic round and saturation for one item.
// ----------------------------------------------------------------------------
module fp8sr_convert (
  input  logic [fp8sr_pkg::CfgW-1:0]  exp_bits_i,
  input  logic [fp8sr_pkg::Fp32W-1:0] float_bits_i,
  input  logic [fp8sr_pkg::RndW-1:0]  random_word_i,
  output logic [fp8sr_pkg::Fp8W-1:0]  small_float_o
);
  import fp8sr_pkg::*;

  always_comb begin
    logic [CfgW-1:0]     e_eff;
    logic [CfgW-1:0]     m_bits;
    logic [4:0]          drop;
    logic [6:0]          pow_e;
    logic [6:0]          exp_max;
    logic [5:0]          man_max;
    logic signed [9:0]   bias;
    logic signed [9:0]   te;
    logic signed [9:0]   sh;
    logic                sign;
    logic [7:0]          exp8;
    logic [FracW-1:0]    frac;
    logic [FracW:0]      man;
    logic [FracW:0]      dmask;
    logic [FracW:0]      rem;
    logic [FracW:0]      rnd_m;
    logic [FracW:0]      man_sh;
    logic [5:0]          trunc;
    logic [6:0]          exp_out;
    logic                sat;

    e_eff = exp_bits_i;
    if (exp_bits_i < ExpBitsMin) e_eff = ExpBitsMin;
    if (exp_bits_i > ExpBitsMax) e_eff = ExpBitsMax;
    m_bits  = MantPlusExp - e_eff;
    drop    = DropBase + {2'b00, e_eff};
    pow_e   = 7'd1 << e_eff;
    exp_max = pow_e - 7'd1;
    man_max = (6'd1 << m_bits) - 6'd1;
    bias    = $signed({4'b0000, exp_max[6:1]});

    sign = float_bits_i[Fp32W-1];
    exp8 = float_bits_i[Fp32W-2:FracW];
    frac = float_bits_i[FracW-1:0];

    te      = $signed({2'b00, exp8}) - Fp32Bias + bias;
    sh      = 10'sd1 - te;
    sat     = (exp8 == Fp32ExpAllOnes) || (te >= $signed({3'b000, pow_e}));
    exp_out = '0;

    if (te < 10'sd1) begin
      if (sh >= 10'sd24) begin
        man = '0;
      end else begin
        man = {1'b1, frac} >> sh[4:0];
      end
    end else begin
      man     = {1'b0, frac};
      exp_out = te[6:0];
    end

    dmask  = ((FracW+1)'(1) << drop) - (FracW+1)'(1);
    rem    = man & dmask;
    rnd_m  = {1'b0, random_word_i} & dmask;
    man_sh = man >> drop;
    trunc  = man_sh[5:0] & man_max;

    if (rnd_m < rem) trunc = trunc + 6'd1;
    if (trunc > man_max) begin
      trunc   = '0;
      exp_out = exp_out + 7'd1;
      if (exp_out > exp_max) sat = 1'b1;
    end

    if (sat) begin
      small_float_o = {sign, MagAllOnes};
    end else begin
      small_float_o = {sign, 7'(exp_out << m_bits) | {1'b0, trunc}};
    end
  end

endmodule

// ----- rtl/fp32_to_fp8_stochastic_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_to_fp8_stochastic_round: streaming FP32 to FP8 converter
// Converts single-precision items to an 8-bit float with configurable
// exponent width, using a per-item random word for stochastic rounding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries float_bits_i and
//   random_word_i; an item is taken when both are high.
//   Output channel (out_valid_o / out_ready_i) carries small_float_o.
//   cfg_we_i writes cfg_wdata_i into the exponent width register; write it
//   only while no item is in flight. Widths below 2 act as 2, above 6 as 6.
// Timing:
//   An item is captured in an input register, converted in one pass of
//   logic, and held in the result register; out_valid_o rises when the
//   result register is loaded. Throughput is 1 item per cycle while the
//   receiver does not stall, set by the two-stage register pipeline with
//   a single conversion pass between them.
// Reset and stall:
//   Reset empties both stages and sets the exponent width to 4.
//   While the receiver stalls, the result holds and one more item can sit
//   in the input register; in_ready_o drops only when both are full.
// ----------------------------------------------------------------------------
module fp32_to_fp8_stochastic_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fp8sr_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fp8sr_pkg::Fp32W-1:0] float_bits_i,
  input  logic [fp8sr_pkg::RndW-1:0]  random_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fp8sr_pkg::Fp8W-1:0]  small_float_o
);
  import fp8sr_pkg::*;

  logic [CfgW-1:0]  exp_bits_q;
  logic             in_valid_q;
  logic [Fp32W-1:0] float_q;
  logic [RndW-1:0]  rnd_q;
  logic             out_valid_q;
  logic [Fp8W-1:0]  result_q;
  logic [Fp8W-1:0]  result_d;
  logic             out_free;
  logic             in_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q <= ExpBitsReset;
    end else if (cfg_we_i) begin
      exp_bits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      float_q <= float_bits_i;
      rnd_q   <= random_word_i;
    end
    if (out_free && in_valid_q) result_q <= result_d;
  end

  fp8sr_convert u_convert (
    .exp_bits_i    (exp_bits_q),
    .float_bits_i  (float_q),
    .random_word_i (rnd_q),
    .small_float_o (result_d)
  );

  assign out_valid_o   = out_valid_q;
  assign small_float_o = result_q;

endmodule

// ----- rtl/fp8sr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp8sr_checker: port-level checks for the FP32 to FP8 converter
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module fp8sr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [fp8sr_pkg::Fp8W-1:0] small_float_o
);
  import fp8sr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(small_float_o))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted item");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

endmodule

bind fp32_to_fp8_stochastic_round fp8sr_checker u_fp8sr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .small_float_o (small_float_o)
);
